### rtl/core/ftg_pkg.sv
`timescale 1ns / 1ps

package ftg_pkg;

    localparam int MAX_EXPANDED = 32;
    localparam int IDX_W = $clog2(MAX_EXPANDED);
    localparam int CNT_W = $clog2(MAX_EXPANDED + 1);
    localparam int POS_W = 16;
    localparam int CHILD_W = POS_W + 1;
    localparam int ACT_W = 3;
    localparam int KIND_W = 2;
    localparam int ERR_W = 2;
    localparam int TIDX_W = 6;
    localparam int WIDE_W = POS_W + 3;

    localparam logic [ACT_W-1:0] ACT_CLEAR      = 3'd0;
    localparam logic [ACT_W-1:0] ACT_APPEND     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FLAT2GRP   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GRP2FLAT   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CHILD2FLAT = 3'd4;

    localparam logic [KIND_W-1:0] KIND_GROUP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHILD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOSHOW  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UPDATED = 2'd3;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ORDER = 2'd2;

    localparam logic [CHILD_W-1:0] CHILD_NONE = {CHILD_W{1'b1}};
    localparam logic signed [WIDE_W-1:0] POS_MAX_WIDE = WIDE_W'({POS_W{1'b1}});

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FIN
    } ftg_state_t;

    typedef struct packed {
        logic [POS_W-1:0] group;
        logic [POS_W-1:0] first;
        logic [POS_W-1:0] last;
    } ftg_entry_t;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [POS_W-1:0] flat;
        logic [POS_W-1:0] group;
        logic [POS_W-1:0] child;
        logic [POS_W-1:0] count;
    } ftg_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic [POS_W-1:0] running_flat;
        logic [POS_W-1:0] previous_group;
        logic [POS_W-1:0] children_sum;
    } ftg_ctx_t;

    typedef struct packed {
        logic             hit;
        logic             child_hit;
        logic             after;
        logic [CNT_W-1:0] idx;
        ftg_entry_t       ent;
    } ftg_find_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   flat;
        logic [POS_W-1:0]   group;
        logic [CHILD_W-1:0] child;
        logic               expanded;
        logic [TIDX_W-1:0]  tidx;
        logic [POS_W-1:0]   total;
        logic [ERR_W-1:0]   err;
    } ftg_res_t;

    typedef struct packed {
        logic             wr;
        logic             clr;
        logic [POS_W-1:0] last;
    } ftg_upd_t;

    typedef struct packed {
        logic             over;
        logic [POS_W-1:0] val;
    } ftg_sat_t;

    function automatic ftg_sat_t sat_flat(input logic signed [WIDE_W-1:0] v);
        ftg_sat_t s;
        s.over = 1'b0;
        s.val = v[POS_W-1:0];
        if (v > POS_MAX_WIDE)
        begin
            s.over = 1'b1;
            s.val = {POS_W{1'b1}};
        end
        else if (v < 0)
        begin
            s.val = '0;
        end
        return s;
    endfunction

    function automatic logic signed [WIDE_W-1:0] widen(input logic [POS_W-1:0] x);
        return $signed({3'b000, x});
    endfunction

endpackage

### rtl/core/ftg_calc.sv
`timescale 1ns / 1ps

module ftg_calc (
    input  ftg_pkg::ftg_req_t  req,
    input  ftg_pkg::ftg_ctx_t  ctx,
    input  ftg_pkg::ftg_find_t find,
    output ftg_pkg::ftg_res_t  res,
    output ftg_pkg::ftg_upd_t  upd
);

    logic                                 empty;
    logic                                 hit;
    logic                                 child_q;
    logic signed [ftg_pkg::WIDE_W-1:0]    first_w;
    logic signed [ftg_pkg::WIDE_W-1:0]    last_w;
    logic signed [ftg_pkg::WIDE_W-1:0]    qv;
    ftg_pkg::ftg_sat_t                    qs;

    assign empty = (ctx.entry_count == '0);
    assign hit = find.hit && !empty;
    assign child_q = (req.action == ftg_pkg::ACT_CHILD2FLAT);

    // append positions
    assign first_w = ftg_pkg::widen(ctx.running_flat) + ftg_pkg::widen(req.group)
                   - ftg_pkg::widen(ctx.previous_group);
    assign last_w = first_w + ftg_pkg::widen(req.count);

    // flat position of a group or child query
    always_comb
    begin
        if (hit)
        begin
            qv = ftg_pkg::widen(find.ent.first);
            if (child_q)
            begin
                qv = qv + ftg_pkg::widen(req.child) + ftg_pkg::WIDE_W'(1);
            end
        end
        else if (find.after)
        begin
            qv = ftg_pkg::widen(find.ent.last) + ftg_pkg::widen(req.group)
               - ftg_pkg::widen(find.ent.group);
        end
        else
        begin
            qv = ftg_pkg::widen(find.ent.first) - ftg_pkg::widen(find.ent.group)
               + ftg_pkg::widen(req.group);
        end
    end

    assign qs = ftg_pkg::sat_flat(qv);

    always_comb
    begin
        res = '0;
        res.kind = ftg_pkg::KIND_UPDATED;
        res.total = ctx.children_sum;
        res.err = ftg_pkg::ERR_OK;
        upd = '0;
        upd.last = last_w[ftg_pkg::POS_W-1:0];
        unique case (req.action) inside
            ftg_pkg::ACT_CLEAR:
            begin
                upd.clr = 1'b1;
                res.total = '0;
            end
            ftg_pkg::ACT_APPEND:
            begin
                if (ctx.entry_count == ftg_pkg::CNT_W'(ftg_pkg::MAX_EXPANDED))
                begin
                    res.err = ftg_pkg::ERR_FULL;
                end
                else if (!empty && req.group <= ctx.previous_group)
                begin
                    res.err = ftg_pkg::ERR_ORDER;
                end
                else if (first_w < 0 || last_w > ftg_pkg::POS_MAX_WIDE)
                begin
                    res.err = ftg_pkg::ERR_ORDER;
                end
                else
                begin
                    upd.wr = 1'b1;
                    res.flat = first_w[ftg_pkg::POS_W-1:0];
                    res.group = req.group;
                    res.child = ftg_pkg::CHILD_NONE;
                    res.expanded = 1'b1;
                    res.tidx = ftg_pkg::TIDX_W'(ctx.entry_count);
                    res.total = ctx.children_sum + req.count;
                end
            end
            ftg_pkg::ACT_FLAT2GRP:
            begin
                res.kind = ftg_pkg::KIND_GROUP;
                res.flat = req.flat;
                res.child = ftg_pkg::CHILD_NONE;
                if (empty)
                begin
                    res.group = req.flat;
                end
                else
                begin
                    res.tidx = ftg_pkg::TIDX_W'(find.idx);
                    if (hit)
                    begin
                        res.expanded = 1'b1;
                        res.group = find.ent.group;
                        if (find.child_hit)
                        begin
                            res.kind = ftg_pkg::KIND_CHILD;
                            res.child = {1'b0, req.flat} - {1'b0, find.ent.first}
                                      - ftg_pkg::CHILD_W'(1);
                        end
                    end
                    else if (find.after)
                    begin
                        res.group = req.flat - find.ent.last + find.ent.group;
                    end
                    else
                    begin
                        res.group = find.ent.group - find.ent.first + req.flat;
                    end
                end
            end
            ftg_pkg::ACT_GRP2FLAT, ftg_pkg::ACT_CHILD2FLAT:
            begin
                res.group = req.group;
                res.child = child_q ? {1'b0, req.child} : ftg_pkg::CHILD_NONE;
                res.kind = child_q ? ftg_pkg::KIND_CHILD : ftg_pkg::KIND_GROUP;
                if (!empty)
                begin
                    res.tidx = ftg_pkg::TIDX_W'(find.idx);
                end
                if (hit)
                begin
                    res.expanded = 1'b1;
                    res.flat = qs.val;
                    res.err = qs.over ? ftg_pkg::ERR_ORDER : ftg_pkg::ERR_OK;
                end
                else if (child_q)
                begin
                    res.kind = ftg_pkg::KIND_NOSHOW;
                end
                else if (empty)
                begin
                    res.flat = req.group;
                end
                else
                begin
                    res.flat = qs.val;
                    res.err = qs.over ? ftg_pkg::ERR_ORDER : ftg_pkg::ERR_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/core/flat_to_group_position_map_top.sv
`timescale 1ns / 1ps

// Translates between flat list positions and group/child positions of an
// expandable list, using a table of up to 32 expanded groups held in a
// single-port synchronous memory. Clear and append items, and a query on an
// empty table, go from acceptance straight to the finish state, which loads
// their result into the output register once that register is free. Other
// queries run a binary search with one registered table read per step, at
// most log2(entries)+1 steps, then reach the finish state and load the result
// the same way. One item is worked on at a time, and the next item is taken
// while a finished result still waits in the output register.
module flat_to_group_position_map_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // flat_pos, group_pos, child_pos, child_count
    input  logic [63:0] s_tdata,
    // action
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_flat_pos, out_group_pos, out_child_pos, is_expanded, table_index,
    // total_children, error, zero fill
    output logic [79:0] m_tdata,
    // kind
    output logic [1:0]  m_tuser
);

    ftg_pkg::ftg_state_t state_reg, state_next;
    ftg_pkg::ftg_req_t   req_reg;
    ftg_pkg::ftg_ctx_t   ctx_reg;
    logic [ftg_pkg::CNT_W-1:0] lo_reg, hip1_reg;
    logic [ftg_pkg::IDX_W-1:0] mid_reg;
    logic hit_reg, chit_reg, after_reg;

    ftg_pkg::ftg_entry_t mem [ftg_pkg::MAX_EXPANDED];
    ftg_pkg::ftg_entry_t rd_data_reg;

    logic        m_tvalid_reg;
    logic [79:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    logic accept, load, rd_en, is_query;
    logic [ftg_pkg::IDX_W-1:0] rd_addr;

    logic by_flat, gt, lt;
    logic [ftg_pkg::CNT_W-1:0] lo_n, hip1_n, mid_sum, mid_sum_n;
    logic [ftg_pkg::IDX_W-1:0] mid_first, mid_n;
    logic cont;

    ftg_pkg::ftg_find_t find;
    ftg_pkg::ftg_res_t  res;
    ftg_pkg::ftg_upd_t  upd;

    assign accept = s_tvalid && s_tready;
    assign is_query = (s_tuser == ftg_pkg::ACT_FLAT2GRP) || (s_tuser == ftg_pkg::ACT_GRP2FLAT)
                   || (s_tuser == ftg_pkg::ACT_CHILD2FLAT);

    // search step
    assign by_flat = (req_reg.action == ftg_pkg::ACT_FLAT2GRP);
    assign gt = by_flat ? (req_reg.flat > rd_data_reg.last) : (req_reg.group > rd_data_reg.group);
    assign lt = by_flat ? (req_reg.flat < rd_data_reg.first) : (req_reg.group < rd_data_reg.group);
    assign lo_n = gt ? ({1'b0, mid_reg} + ftg_pkg::CNT_W'(1)) : lo_reg;
    assign hip1_n = lt ? {1'b0, mid_reg} : hip1_reg;
    assign cont = (gt || lt) && (lo_n < hip1_n);
    assign mid_sum = lo_reg + hip1_reg - ftg_pkg::CNT_W'(1);
    assign mid_sum_n = lo_n + hip1_n - ftg_pkg::CNT_W'(1);
    assign mid_first = mid_sum[ftg_pkg::CNT_W-1:1];
    assign mid_n = mid_sum_n[ftg_pkg::CNT_W-1:1];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ftg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (is_query && ctx_reg.entry_count != '0) ? ftg_pkg::ST_READ
                                                                          : ftg_pkg::ST_FIN;
                end
            end
            ftg_pkg::ST_READ:
            begin
                state_next = ftg_pkg::ST_CMP;
            end
            ftg_pkg::ST_CMP:
            begin
                if (!cont)
                begin
                    state_next = ftg_pkg::ST_FIN;
                end
            end
            ftg_pkg::ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ftg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ftg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        rd_en = 1'b0;
        rd_addr = mid_first;
        load = 1'b0;
        unique case (state_reg)
            ftg_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ftg_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            ftg_pkg::ST_CMP:
            begin
                rd_en = cont;
                rd_addr = mid_n;
            end
            ftg_pkg::ST_FIN:
            begin
                load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        find.hit = hit_reg;
        find.child_hit = chit_reg;
        find.after = after_reg;
        find.ent = rd_data_reg;
        if (!hit_reg && after_reg)
        begin
            find.idx = {1'b0, mid_reg} + ftg_pkg::CNT_W'(1);
        end
        else
        begin
            find.idx = {1'b0, mid_reg};
        end
    end

    ftg_calc u_calc (
        .req  (req_reg),
        .ctx  (ctx_reg),
        .find (find),
        .res  (res),
        .upd  (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftg_pkg::ST_IDLE;
            ctx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                m_tvalid_reg <= 1'b1;
                if (upd.clr)
                begin
                    ctx_reg <= '0;
                end
                else if (upd.wr)
                begin
                    ctx_reg.entry_count <= ctx_reg.entry_count + ftg_pkg::CNT_W'(1);
                    ctx_reg.running_flat <= upd.last;
                    ctx_reg.previous_group <= req_reg.group;
                    ctx_reg.children_sum <= res.total;
                end
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.action <= s_tuser;
            req_reg.flat <= s_tdata[15:0];
            req_reg.group <= s_tdata[31:16];
            req_reg.child <= s_tdata[47:32];
            req_reg.count <= s_tdata[63:48];
            lo_reg <= '0;
            hip1_reg <= ctx_reg.entry_count;
            hit_reg <= 1'b0;
            chit_reg <= 1'b0;
            after_reg <= 1'b0;
        end
        if (state_reg == ftg_pkg::ST_READ)
        begin
            mid_reg <= mid_first;
        end
        if (state_reg == ftg_pkg::ST_CMP)
        begin
            lo_reg <= lo_n;
            hip1_reg <= hip1_n;
            after_reg <= gt;
            if (!gt && !lt)
            begin
                hit_reg <= 1'b1;
                chit_reg <= by_flat && (req_reg.flat != rd_data_reg.first);
            end
            if (cont)
            begin
                mid_reg <= mid_n;
            end
        end
        if (load)
        begin
            m_tdata_reg <= {6'b0, res.err, res.total, res.tidx, res.expanded,
                            res.child, res.group, res.flat};
            m_tuser_reg <= res.kind;
        end
    end

    // entry table
    always_ff @(posedge clk)
    begin
        if (load && upd.wr)
        begin
            mem[ctx_reg.entry_count[ftg_pkg::IDX_W-1:0]] <= '{group: req_reg.group,
                                                              first: res.flat,
                                                              last:  upd.last};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        ctx_reg.entry_count <= ftg_pkg::CNT_W'(ftg_pkg::MAX_EXPANDED))
        else $error("entry count beyond table depth");

    a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftg_pkg::ST_CMP) |->
            ({1'b0, mid_reg} >= lo_reg) && ({1'b0, mid_reg} < hip1_reg))
        else $error("search index outside bounds");

    a_bound_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftg_pkg::ST_CMP) |-> (hip1_reg <= ctx_reg.entry_count))
        else $error("search bound beyond filled entries");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (m_tvalid_reg && state_reg == ftg_pkg::ST_IDLE))
        else $error("result load did not return to idle with valid output");

endmodule
